// ----- rtl/core/dibp_pkg.sv -----
// ----------------------------------------------------------------------------
// dibp_pkg
// Shared types and constants of the dictionary index bit packer: input mode
// and status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dibp_pkg;

  localparam int DIBP_MAX_SYMBOLS = 64;
  localparam int BYTE_W           = 8;

  typedef enum logic [1:0] {
    MODE_LEARN  = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } dibp_mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } dibp_status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_CMP    = 2'd2,
    S_FINISH = 2'd3
  } dibp_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;    // latch the accepted beat, rewind the search pointer
    logic issue;    // read the table at the search pointer, advance it
    logic compare;  // compare the registered table entry with the symbol
    logic commit;   // update packer state and load the result register
  } dibp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;  // table is empty
    logic hit;         // registered entry matches the symbol
    logic last;        // registered entry is the last learned one
    logic out_free;    // result register can take a new beat
  } dibp_stat_t;

endpackage

// ----- rtl/core/dibp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dibp_ctrl
// Controller: sequences accept, table search and commit of one item.
// ----------------------------------------------------------------------------
module dibp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  output logic                in_ready,
  input  dibp_pkg::dibp_stat_t stat,
  output dibp_pkg::dibp_cmd_t  cmd
);
  import dibp_pkg::*;

  dibp_state_t state_r;
  dibp_state_t state_nxt;
  logic        go_search;

  assign go_search = ((in_mode == MODE_LEARN) || (in_mode == MODE_ENCODE)) &&
                     !stat.count_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = go_search ? S_READ : S_FINISH;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.hit || stat.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.start   = 1'b0;
    cmd.issue   = 1'b0;
    cmd.compare = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_READ: begin
        cmd.issue = 1'b1;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        cmd.issue   = !stat.hit && !stat.last;
      end
      S_FINISH: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/dibp_dpath.sv -----
// ----------------------------------------------------------------------------
// dibp_dpath
// Datapath: symbol table memory, search pointer, bit packer and result
// register.
// ----------------------------------------------------------------------------
module dibp_dpath #(
  parameter int MAX_SYMBOLS = dibp_pkg::DIBP_MAX_SYMBOLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_mode,
  input  logic [7:0]           in_symbol,
  input  dibp_pkg::dibp_cmd_t  cmd,
  output dibp_pkg::dibp_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_byte_valid,
  output logic [7:0]           out_packed_byte,
  output logic [1:0]           out_status,
  output logic [6:0]           out_symbol_count,
  output logic [2:0]           out_code_width
);
  import dibp_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam int WID_W = $clog2(CNT_W + 1);
  localparam int PK_W  = 2 * BYTE_W;

  // bit length of a count
  function automatic logic [WID_W-1:0] width_f(input logic [CNT_W-1:0] c);
    logic [WID_W-1:0] w;
    w = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (c[i]) begin
        w = WID_W'(i + 1);
      end
    end
    return w;
  endfunction

  logic [BYTE_W-1:0] mem [MAX_SYMBOLS];

  logic [1:0]        mode_r;
  logic [7:0]        sym_r;
  logic [CNT_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  cmp_idx_r;
  logic [7:0]        rd_data_r;
  logic              found_r;
  logic [IDX_W-1:0]  idx_r;

  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [7:0]        acc_r,    acc_nxt;
  logic [2:0]        bp_r,     bp_nxt;

  logic              out_valid_r;
  logic              out_bv_r;
  logic [7:0]        out_byte_r;
  logic [1:0]        out_status_r;
  logic [6:0]        out_count_r;
  logic [2:0]        out_width_r;

  logic              byte_valid_nxt;
  logic [7:0]        byte_nxt;
  dibp_status_t      status_nxt;
  logic              mem_we;

  logic [WID_W-1:0]  width_cur;
  logic [PK_W-1:0]   joined;
  logic [4:0]        total;
  logic [4:0]        rem;
  logic [PK_W-1:0]   rem_mask;

  assign stat.count_zero = (count_r == '0);
  assign stat.hit        = (rd_data_r == sym_r);
  assign stat.last       = ((cmp_idx_r + CNT_W'(1)) == count_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  // pack the index behind the pending bits, MSB first
  assign width_cur = width_f(count_r);
  assign joined    = (PK_W'(acc_r) << width_cur) | PK_W'(idx_r);
  assign total     = 5'(bp_r) + 5'(width_cur);
  assign rem       = total - 5'(BYTE_W);
  assign rem_mask  = (PK_W'(1) << rem) - PK_W'(1);

  always_comb begin
    count_nxt      = count_r;
    acc_nxt        = acc_r;
    bp_nxt         = bp_r;
    byte_valid_nxt = 1'b0;
    byte_nxt       = '0;
    status_nxt     = ST_OK;
    mem_we         = 1'b0;
    case (mode_r)
      MODE_LEARN: begin
        if (!found_r) begin
          if (count_r < CNT_W'(MAX_SYMBOLS)) begin
            mem_we    = cmd.commit;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            status_nxt = ST_FULL;
          end
        end
      end
      MODE_ENCODE: begin
        if (found_r) begin
          if (total >= 5'(BYTE_W)) begin
            byte_valid_nxt = 1'b1;
            byte_nxt       = 8'(joined >> rem);
            acc_nxt        = 8'(joined & rem_mask);
            bp_nxt         = 3'(rem);
          end else begin
            acc_nxt = 8'(joined);
            bp_nxt  = 3'(total);
          end
        end else begin
          status_nxt = ST_UNKNOWN;
        end
      end
      MODE_FLUSH: begin
        if (bp_r != '0) begin
          byte_valid_nxt = 1'b1;
          byte_nxt       = 8'(acc_r << (4'(BYTE_W) - 4'(bp_r)));
          acc_nxt        = '0;
          bp_nxt         = '0;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= sym_r;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  // beat capture and search pointer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= in_mode;
      sym_r  <= in_symbol;
      ptr_r  <= '0;
    end else if (cmd.issue) begin
      ptr_r     <= ptr_r + CNT_W'(1);
      cmp_idx_r <= ptr_r;
    end
    if (cmd.compare && stat.hit) begin
      idx_r <= cmp_idx_r[IDX_W-1:0];
    end
  end

  // packer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      acc_r       <= '0;
      bp_r        <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        found_r <= 1'b0;
      end else if (cmd.compare && stat.hit) begin
        found_r <= 1'b1;
      end
      if (cmd.commit) begin
        count_r     <= count_nxt;
        acc_r       <= acc_nxt;
        bp_r        <= bp_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_bv_r     <= byte_valid_nxt;
      out_byte_r   <= byte_nxt;
      out_status_r <= status_nxt;
      out_count_r  <= 7'(count_nxt);
      out_width_r  <= 3'(width_f(count_nxt));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_valid   = out_bv_r;
  assign out_packed_byte  = out_byte_r;
  assign out_status       = out_status_r;
  assign out_symbol_count = out_count_r;
  assign out_code_width   = out_width_r;

endmodule

// ----- rtl/core/dictionary_index_bit_packer_core.sv -----
// Items are handled one at a time: a new item is accepted only after the
//   previous one is committed. Learn and encode search the table first,
//   reading one table entry a cycle through the single read port; flush,
//   unused mode or an empty table go straight to the commit.
// Reset: synchronous, active-low rst_n clears the entry count, the bit
//   accumulator and the output valid; table contents stay undefined.
// ----------------------------------------------------------------------------
// dictionary_index_bit_packer_core
// Fixed-length dictionary coder: learns distinct byte symbols into a table,
// encodes bytes as table indexes of floor(log2(count))+1 bits and packs them
// MSB first into output bytes; flush pads the pending bits with zeros.
// ----------------------------------------------------------------------------
module dictionary_index_bit_packer_core #(
  parameter int MAX_SYMBOLS = dibp_pkg::DIBP_MAX_SYMBOLS
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_symbol,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_byte_valid,
  output logic [7:0] out_packed_byte,
  output logic [1:0] out_status,
  output logic [6:0] out_symbol_count,
  output logic [2:0] out_code_width
);
  import dibp_pkg::*;

  // Control and datapath talk only through these two bundles:
  //   cmd  - start/issue/compare/commit strobes from the controller
  //   stat - search outcome and result-register room from the datapath
  dibp_cmd_t  cmd;
  dibp_stat_t stat;

  // Controller: idle -> (read -> compare loop) -> finish -> idle.
  // A beat is taken only in idle; the finish state holds until the result
  // register is free, so a result waiting downstream never gets overwritten.
  dibp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: table memory with a registered read, a linear search over the
  // learned entries (one per cycle), the bit accumulator and the result
  // register that decouples the output handshake from the next item.
  dibp_dpath #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_symbol        (in_symbol),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_valid   (out_byte_valid),
    .out_packed_byte  (out_packed_byte),
    .out_status       (out_status),
    .out_symbol_count (out_symbol_count),
    .out_code_width   (out_code_width)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dictionary_index_bit_packer_core. A queue of input
// beats feeds a valid/ready driver; a behavioral packer predicts one result
// per accepted beat and a monitor compares every returned beat field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dibp_pkg::*;

  // Mode three has no name in the package; the block must ignore it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TABLE_DEPTH  = DIBP_MAX_SYMBOLS;
  localparam int PHASE_BEATS  = 460;
  localparam int QUIET_LIMIT  = 3000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 100;   // longer than the worst-case search

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
  } sym_beat_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] packed_byte;
    logic [1:0] status;
    logic [6:0] symbol_count;
    logic [2:0] code_width;
  } code_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = MODE_FLUSH;
  logic [7:0] in_symbol = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_byte_valid;
  logic [7:0] out_packed_byte;
  logic [1:0] out_status;
  logic [6:0] out_symbol_count;
  logic [2:0] out_code_width;

  dictionary_index_bit_packer_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_valid  (out_byte_valid),
    .out_packed_byte (out_packed_byte),
    .out_status      (out_status),
    .out_symbol_count(out_symbol_count),
    .out_code_width  (out_code_width)
  );

  // Beats waiting to be driven, and packer results waiting to come back.
  sym_beat_t  pending_beats[$];
  code_beat_t expected_codes[$];

  // Idle rates in percent, changed per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Packer model: symbol dictionary plus the MSB-first bit accumulator.
  // --------------------------------------------------------------------------
  logic [7:0] dict_table[TABLE_DEPTH];
  int         dict_count = 0;
  logic [7:0] acc_bits = 8'h00;
  int         acc_fill = 0;

  // Bit length of the entry count: the code width, zero for an empty table.
  function automatic int bit_length(input int value);
    int len;
    len = 0;
    while (value != 0) begin
      len++;
      value = value >> 1;
    end
    return len;
  endfunction

  function automatic code_beat_t pack_symbol(input logic [1:0] mode, input logic [7:0] sym);
    code_beat_t res;
    int         idx;
    int         width;
    idx = -1;
    res = '0;
    res.status = ST_OK;
    for (int i = 0; i < dict_count; i++) begin
      if (idx < 0 && dict_table[i] == sym) idx = i;
    end
    case (mode)
      MODE_LEARN: begin
        // Known symbols leave the table alone; new ones append or hit full.
        if (idx < 0) begin
          if (dict_count < TABLE_DEPTH) begin
            dict_table[dict_count] = sym;
            dict_count++;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      MODE_ENCODE: begin
        if (idx < 0) begin
          res.status = ST_UNKNOWN;
        end else begin
          width = bit_length(dict_count);
          // Shift the index in MSB first; emit each completed byte.
          for (int b = width - 1; b >= 0; b--) begin
            acc_bits = {acc_bits[6:0], idx[b]};
            acc_fill++;
            if (acc_fill == 8) begin
              res.byte_valid  = 1'b1;
              res.packed_byte = acc_bits;
              acc_bits = 8'h00;
              acc_fill = 0;
            end
          end
        end
      end
      MODE_FLUSH: begin
        // Pad the pending bits with zeros on the right.
        if (acc_fill != 0) begin
          res.byte_valid  = 1'b1;
          res.packed_byte = acc_bits << (8 - acc_fill);
          acc_bits = 8'h00;
          acc_fill = 0;
        end
      end
      default: begin
        // Unused mode: no state change, plain ok result.
      end
    endcase
    width = bit_length(dict_count);
    res.symbol_count = dict_count[6:0];
    res.code_width   = width[2:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus bookkeeping: which symbols the table will hold once the queued
  // beats are through, so that encodes can pick known symbols.
  // --------------------------------------------------------------------------
  bit         gen_known[256];
  logic [7:0] gen_learned[$];
  int         gen_count = 0;

  task automatic add_beat(input logic [1:0] mode, input logic [7:0] sym);
    sym_beat_t beat;
    beat.mode   = mode;
    beat.symbol = sym;
    pending_beats.push_back(beat);
    if (mode == MODE_LEARN && !gen_known[sym] && gen_count < TABLE_DEPTH) begin
      gen_known[sym] = 1'b1;
      gen_learned.push_back(sym);
      gen_count++;
    end
  endtask

  // Grow the table slowly so every code width sees plenty of encodes, and
  // fill it well before the end so learns on a full table get exercised.
  task automatic add_random_beat(input int done);
    int         target;
    int         pick;
    logic [7:0] sym;
    target = 4 + (done * 60) / 1200;
    if (target > TABLE_DEPTH) target = TABLE_DEPTH;
    pick = $urandom_range(0, 99);
    sym  = 8'($urandom_range(0, 255));
    if (gen_count < target && pick < 50) begin
      while (gen_known[sym]) sym = 8'($urandom_range(0, 255));
      add_beat(MODE_LEARN, sym);
    end else if (pick < 5) begin
      add_beat(MODE_LEARN, sym);
    end else if (pick < 10) begin
      add_beat(MODE_FLUSH, sym);
    end else if (pick < 12) begin
      add_beat(MODE_UNUSED, sym);
    end else if (pick < 17 || gen_count == 0) begin
      add_beat(MODE_ENCODE, sym);
    end else begin
      add_beat(MODE_ENCODE, gen_learned[$urandom_range(0, gen_count - 1)]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: predict on every accepted beat, then present the next one or idle.
  // --------------------------------------------------------------------------
  sym_beat_t next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_codes.push_back(pack_symbol(in_mode, in_symbol));
      end
      // Hold the current beat until it is taken.
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat = pending_beats.pop_front();
          in_mode   <= next_beat.mode;
          in_symbol <= next_beat.symbol;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string field, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, act_val);
      error_count++;
    end
  endfunction

  code_beat_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          $error("result beat with no prediction pending");
          error_count++;
        end else begin
          want = expected_codes.pop_front();
          check_field("byte_valid", 32'(want.byte_valid), 32'(out_byte_valid));
          check_field("packed_byte", 32'(want.packed_byte), 32'(out_packed_byte));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("symbol_count", 32'(want.symbol_count), 32'(out_symbol_count));
          check_field("code_width", 32'(want.code_width), 32'(out_code_width));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves a beat for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dictionary_index_bit_packer_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random phases with varied idling.
  // --------------------------------------------------------------------------
  initial begin
    int rand_done;
    rand_done = 0;

    // Empty table: flush with nothing pending, unused mode, unknown encodes.
    add_beat(MODE_FLUSH, 8'h00);
    add_beat(MODE_UNUSED, 8'hA5);
    add_beat(MODE_ENCODE, 8'h00);
    add_beat(MODE_ENCODE, 8'hFF);
    // First entry, repeat learn of a known symbol, one-bit code, padded flush.
    add_beat(MODE_LEARN, 8'h00);
    add_beat(MODE_LEARN, 8'h00);
    add_beat(MODE_ENCODE, 8'h00);
    add_beat(MODE_FLUSH, 8'hFF);
    // Two-bit codes, learn after encode keeps the pending bits.
    add_beat(MODE_LEARN, 8'hFF);
    add_beat(MODE_ENCODE, 8'hFF);
    add_beat(MODE_ENCODE, 8'h00);
    add_beat(MODE_ENCODE, 8'h5A);
    add_beat(MODE_LEARN, 8'h80);
    add_beat(MODE_UNUSED, 8'hFF);
    add_beat(MODE_ENCODE, 8'h80);
    add_beat(MODE_FLUSH, 8'h00);
    add_beat(MODE_FLUSH, 8'h00);
    // Three-bit codes crossing a byte boundary.
    add_beat(MODE_LEARN, 8'h01);
    add_beat(MODE_ENCODE, 8'h01);
    add_beat(MODE_ENCODE, 8'h01);
    add_beat(MODE_ENCODE, 8'h01);
    add_beat(MODE_FLUSH, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        add_random_beat(rand_done);
        rand_done++;
      end
      while (pending_beats.size() != 0) @(posedge clk);
    end

    // Wait for the last beat to be taken and its result to come back.
    while (in_valid || expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_codes.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("dictionary_index_bit_packer_core: match");
    end else begin
      $display("dictionary_index_bit_packer_core: mismatch");
    end
    $finish;
  end

endmodule
